[hdl/htq_pkg.sv]
package htq_pkg;

  // Sizes of the queue and of the item fields.
  localparam int CAPACITY = 32;
  localparam int SLOT_W   = 5;
  localparam int CNT_W    = 6;
  localparam int ID_SPACE = 256;
  localparam int ID_W     = 8;
  localparam int TIME_W   = 32;
  localparam int TMO_W    = 30;
  localparam int WAIT_W   = 31;
  localparam int MODE_W   = 3;
  localparam int KIND_W   = 3;

  localparam logic [TIME_W-1:0] WAIT_MAX   = TIME_W'(1073741823);
  localparam logic [WAIT_W-1:0] WAIT_EMPTY = '1;

  // Operation codes of an input item.
  localparam logic [MODE_W-1:0] MODE_SET   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FIRE  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TICK  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_QUERY = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd4;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_DONE     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_EXPIRED  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FIRED    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_NOTFOUND = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FULL     = 3'd4;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] expiry;
  } heap_entry_t;

  localparam int ENTRY_W = $bits(heap_entry_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SLOT,
    S_LAST_RD,
    S_DN,
    S_DN_L,
    S_DN_R,
    S_UP,
    S_UP_P,
    S_FIN,
    S_RQ,
    S_ROOT,
    S_EXP,
    S_FINAL
  } state_t;

endpackage

[hdl/htq_if.sv]
interface htq_in_if;
  import htq_pkg::*;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [ID_W-1:0]     timer_id;
  logic [TMO_W-1:0]    timeout_ms;

  modport source (output valid, mode, timer_id, timeout_ms, input ready);
  modport sink (input valid, mode, timer_id, timeout_ms, output ready);
endinterface

interface htq_out_if;
  import htq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [ID_W-1:0]          result_id;
  logic signed [WAIT_W-1:0] wait_ms;
  logic                     last;

  modport source (output valid, kind, result_id, wait_ms, last, input ready);
  modport sink (input valid, kind, result_id, wait_ms, last, output ready);
endinterface

[hdl/htq_ram.sv]
module htq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/heap_timer_queue.sv]
// Timer queue held as a binary min-heap of (id, expiry) with an id-to-slot map.
// Input channel in_ch carries mode, timer_id and timeout_ms; an item is taken
// when valid and ready are high at a clock edge. ready is high only while the
// block is idle, so one item is worked on at a time.
// Output channel out_ch carries kind, result_id, wait_ms and last. Each item
// gives zero or more expired results, then one final result with last set.
// A sift down reads each child in turn, then does the compare and the write
// back; where there is a single child, the compare and write back follow its
// read. A sift up reads the parent, then does the compare and the write back.
// A tick or query also removes each timer that has expired, one by one.
// The output is one register; when the receiver stalls, the block holds in
// its current step until that register is free, and the next input item may
// be accepted in the cycle after the final result is loaded, while it still waits.
// Reset clears the queue, the id map valid bits and the millisecond counter;
// it is ready for items as soon as reset is released.
module heap_timer_queue
  import htq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  htq_in_if.sink      in_ch,
  htq_out_if.source   out_ch
);

  state_t state, state_next;

  logic [MODE_W-1:0]   op;
  logic [ID_W-1:0]     node_id;
  logic [TIME_W-1:0]   node_exp;
  logic [SLOT_W-1:0]   pos;
  logic [CNT_W-1:0]    n;
  logic                moved;
  heap_entry_t         left_r;
  logic [ID_W-1:0]     root_id;
  logic [CNT_W-1:0]    count;
  logic [TIME_W-1:0]   now;
  logic [ID_SPACE-1:0] id_valid;
  logic [KIND_W-1:0]   fin_kind;
  logic [ID_W-1:0]     fin_id;
  logic [WAIT_W-1:0]   fin_wait;

  logic                out_valid;
  logic [KIND_W-1:0]   out_kind;
  logic [ID_W-1:0]     out_id;
  logic [WAIT_W-1:0]   out_wait;
  logic                out_last;

  // Memory ports.
  logic                heap_we;
  logic [SLOT_W-1:0]   heap_waddr;
  heap_entry_t         heap_wdata;
  logic [SLOT_W-1:0]   heap_raddr;
  heap_entry_t         heap_rd;
  logic                slot_we;
  logic [ID_W-1:0]     slot_waddr;
  logic [SLOT_W-1:0]   slot_wdata;
  logic [SLOT_W-1:0]   slot_rd;

  htq_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_heap (
    .clk   (clk),
    .we    (heap_we),
    .waddr (heap_waddr),
    .wdata (heap_wdata),
    .raddr (heap_raddr),
    .rdata (heap_rd)
  );

  htq_ram #(.WIDTH(SLOT_W), .DEPTH(ID_SPACE)) u_slot (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (in_ch.timer_id),
    .rdata (slot_rd)
  );

  // Shared decisions of the handshakes, the sift steps and the expiry checks.
  logic                in_acc;
  logic                out_free;
  logic                out_load;
  logic [CNT_W-1:0]    left_idx;
  logic [CNT_W-1:0]    right_idx;
  logic                has_left;
  logic                has_right;
  logic [SLOT_W-1:0]   pos_m1;
  logic [SLOT_W-1:0]   parent;
  logic                use_right;
  heap_entry_t         cand;
  logic [SLOT_W-1:0]   cand_pos;
  logic                dn_swap;
  logic                up_swap;
  logic                expiring;
  logic                due;
  logic [CNT_W-1:0]    count_m1;
  logic [TIME_W-1:0]   diff;
  logic [WAIT_W-1:0]   wait_calc;
  logic                fire_move;

  assign in_ch.ready = (state == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid || out_ch.ready;
  assign out_load    = ((state == S_EXP) || (state == S_FINAL)) && out_free;

  assign left_idx  = {pos, 1'b1};
  assign right_idx = left_idx + CNT_W'(1);
  assign has_left  = left_idx < n;
  assign has_right = right_idx < n;
  assign pos_m1    = pos - SLOT_W'(1);
  assign parent    = {1'b0, pos_m1[SLOT_W-1:1]};
  assign count_m1  = count - CNT_W'(1);

  always_comb begin
    use_right = (state == S_DN_R) && (heap_rd.expiry < left_r.expiry);
    if (state == S_DN_R) begin
      cand     = use_right ? heap_rd : left_r;
      cand_pos = use_right ? right_idx[SLOT_W-1:0] : left_idx[SLOT_W-1:0];
    end else begin
      cand     = heap_rd;
      cand_pos = left_idx[SLOT_W-1:0];
    end
  end

  assign dn_swap   = cand.expiry < node_exp;
  assign up_swap   = node_exp < heap_rd.expiry;
  assign expiring  = (op == MODE_TICK) || (op == MODE_QUERY);
  assign due       = expiring && (count != '0) && (heap_rd.expiry <= now);
  assign fire_move = id_valid[node_id] && ({1'b0, slot_rd} < count_m1);

  // Wait until the head expires, from the root just read, clamped to WAIT_MAX; all ones when empty.
  always_comb begin
    diff = heap_rd.expiry - now;
    if (count == '0) begin
      wait_calc = WAIT_EMPTY;
    end else if (heap_rd.expiry <= now) begin
      wait_calc = '0;
    end else if (diff > WAIT_MAX) begin
      wait_calc = WAIT_MAX[WAIT_W-1:0];
    end else begin
      wait_calc = diff[WAIT_W-1:0];
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.mode == MODE_SET || in_ch.mode == MODE_FIRE) begin
            state_next = S_SLOT;
          end else if (in_ch.mode == MODE_CLEAR) begin
            state_next = S_FINAL;
          end else begin
            state_next = S_ROOT;
          end
        end
      end
      S_SLOT: begin
        if (op == MODE_SET) begin
          if (id_valid[node_id]) begin
            state_next = S_DN;
          end else if (count == CNT_W'(CAPACITY)) begin
            state_next = S_FINAL;
          end else begin
            state_next = S_UP;
          end
        end else begin
          state_next = fire_move ? S_LAST_RD : S_FINAL;
        end
      end
      S_LAST_RD: state_next = S_DN;
      S_DN: begin
        if (has_left) begin
          state_next = S_DN_L;
        end else begin
          state_next = moved ? S_FIN : S_UP;
        end
      end
      S_DN_L: begin
        if (has_right) begin
          state_next = S_DN_R;
        end else if (dn_swap) begin
          state_next = S_DN;
        end else begin
          state_next = moved ? S_FIN : S_UP;
        end
      end
      S_DN_R: begin
        if (dn_swap) begin
          state_next = S_DN;
        end else begin
          state_next = moved ? S_FIN : S_UP;
        end
      end
      S_UP:   state_next = (pos == '0) ? S_FIN : S_UP_P;
      S_UP_P: state_next = up_swap ? S_UP : S_FIN;
      S_FIN:  state_next = (op == MODE_FIRE) ? S_FINAL : S_RQ;
      S_RQ:   state_next = S_ROOT;
      S_ROOT: state_next = due ? S_EXP : S_FINAL;
      S_EXP: begin
        if (out_free) begin
          state_next = (count_m1 != '0) ? S_LAST_RD : S_RQ;
        end
      end
      S_FINAL: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory controls.
  always_comb begin
    heap_we    = 1'b0;
    heap_waddr = pos;
    heap_wdata = cand;
    slot_we    = 1'b0;
    slot_waddr = cand.id;
    slot_wdata = pos;
    heap_raddr = '0;
    case (state)
      S_SLOT, S_EXP: heap_raddr = count_m1[SLOT_W-1:0];
      S_DN:          heap_raddr = left_idx[SLOT_W-1:0];
      S_DN_L: begin
        heap_raddr = right_idx[SLOT_W-1:0];
        if (!has_right && dn_swap) begin
          heap_we = 1'b1;
          slot_we = 1'b1;
        end
      end
      S_DN_R: begin
        if (dn_swap) begin
          heap_we = 1'b1;
          slot_we = 1'b1;
        end
      end
      S_UP: heap_raddr = parent;
      S_UP_P: begin
        if (up_swap) begin
          heap_we = 1'b1;
          slot_we = 1'b1;
        end
      end
      S_FIN: begin
        heap_we    = 1'b1;
        heap_wdata = '{id: node_id, expiry: node_exp};
        slot_we    = 1'b1;
        slot_waddr = node_id;
      end
      default: heap_raddr = '0;
    endcase
  end

  // Control and data registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      now       <= '0;
      id_valid  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // The output register is loaded when free, else emptied on acceptance.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            op       <= in_ch.mode;
            node_id  <= in_ch.timer_id;
            node_exp <= now + TIME_W'(in_ch.timeout_ms);
            fin_id   <= '0;
            fin_wait <= (in_ch.mode == MODE_CLEAR) ? WAIT_EMPTY : '0;
            if (in_ch.mode == MODE_TICK) begin
              now <= now + TIME_W'(1);
            end
            if (in_ch.mode == MODE_CLEAR) begin
              id_valid <= '0;
              count    <= '0;
              fin_kind <= KIND_DONE;
            end
          end
        end
        S_SLOT: begin
          if (op == MODE_SET) begin
            if (id_valid[node_id]) begin
              pos   <= slot_rd;
              n     <= count;
              moved <= 1'b0;
            end else if (count == CNT_W'(CAPACITY)) begin
              fin_kind <= KIND_FULL;
            end else begin
              pos               <= count[SLOT_W-1:0];
              count             <= count + CNT_W'(1);
              id_valid[node_id] <= 1'b1;
            end
          end else if (!id_valid[node_id]) begin
            fin_kind <= KIND_NOTFOUND;
          end else begin
            fin_kind          <= KIND_FIRED;
            fin_id            <= node_id;
            id_valid[node_id] <= 1'b0;
            count             <= count_m1;
            n                 <= count_m1;
            pos               <= slot_rd;
          end
        end
        S_LAST_RD: begin
          node_id  <= heap_rd.id;
          node_exp <= heap_rd.expiry;
          moved    <= 1'b0;
        end
        S_DN_L: begin
          left_r <= heap_rd;
          if (!has_right && dn_swap) begin
            pos   <= cand_pos;
            moved <= 1'b1;
          end
        end
        S_DN_R: begin
          if (dn_swap) begin
            pos   <= cand_pos;
            moved <= 1'b1;
          end
        end
        S_UP_P: begin
          if (up_swap) begin
            pos <= parent;
          end
        end
        S_ROOT: begin
          root_id <= heap_rd.id;
          if (!due) begin
            fin_kind <= KIND_DONE;
            fin_id   <= '0;
            fin_wait <= wait_calc;
          end
        end
        S_EXP: begin
          if (out_free) begin
            out_kind          <= KIND_EXPIRED;
            out_id            <= root_id;
            out_wait          <= '0;
            out_last          <= 1'b0;
            id_valid[root_id] <= 1'b0;
            count             <= count_m1;
            n                 <= count_m1;
            pos               <= '0;
          end
        end
        S_FINAL: begin
          if (out_free) begin
            out_kind  <= fin_kind;
            out_id    <= fin_id;
            out_wait  <= fin_wait;
            out_last  <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.kind      = out_kind;
  assign out_ch.result_id = out_id;
  assign out_ch.wait_ms   = out_wait;
  assign out_ch.last      = out_last;

endmodule

[verif/htq_test_if.sv]
`timescale 1ns / 1ps
// Channel interfaces are supplied by the RTL (hdl/htq_if.sv); this file keeps
// the small shared definitions of the testbench.
package htq_test_pkg;
  import htq_pkg::*;

  // One expected result item.
  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [ID_W-1:0]          result_id;
    logic signed [WAIT_W-1:0] wait_ms;
    logic                     last;
  } timer_result_t;
endpackage

[verif/htq_checker.sv]
`timescale 1ns / 1ps
module htq_checker
  import htq_pkg::*;
  import htq_test_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  htq_in_if     in_ch,
  htq_out_if    out_ch,
  output int    fail_count,
  output int    pending_count
);

  // Shadow copy of the timer heap.
  logic [ID_W-1:0]   sh_id[CAPACITY];
  logic [TIME_W-1:0] sh_exp[CAPACITY];
  int                sh_slot[ID_SPACE];
  bit                sh_valid[ID_SPACE];
  int                sh_count;
  logic [TIME_W-1:0] sh_now;
  timer_result_t     expected_results[$];

  assign pending_count = expected_results.size();

  function automatic void swap_entries(int a, int b);
    logic [ID_W-1:0]   tid;
    logic [TIME_W-1:0] te;
    tid = sh_id[a]; te = sh_exp[a];
    sh_id[a] = sh_id[b]; sh_exp[a] = sh_exp[b];
    sh_id[b] = tid; sh_exp[b] = te;
    sh_slot[sh_id[a]] = a;
    sh_slot[sh_id[b]] = b;
  endfunction

  function automatic void raise_entry(int i);
    int p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (sh_exp[i] < sh_exp[p]) begin
        swap_entries(i, p);
        i = p;
      end else begin
        break;
      end
    end
  endfunction

  function automatic bit lower_entry(int i, int n);
    int start;
    int l;
    int c;
    start = i;
    forever begin
      l = 2 * i + 1;
      if (l >= n) break;
      c = l;
      if (l + 1 < n && sh_exp[l + 1] < sh_exp[l]) c = l + 1;
      if (sh_exp[c] < sh_exp[i]) begin
        swap_entries(i, c);
        i = c;
      end else begin
        break;
      end
    end
    return i != start;
  endfunction

  function automatic void drop_entry(int i);
    int n;
    n = sh_count - 1;
    if (i < n) begin
      swap_entries(i, n);
      if (!lower_entry(i, n)) raise_entry(i);
    end
    sh_valid[sh_id[n]] = 0;
    sh_count = n;
  endfunction

  function automatic logic [WAIT_W-1:0] next_wait();
    logic [TIME_W-1:0] d;
    if (sh_count == 0) return WAIT_EMPTY;
    if (sh_exp[0] <= sh_now) return '0;
    d = sh_exp[0] - sh_now;
    if (d > WAIT_MAX) d = WAIT_MAX;
    return d[WAIT_W-1:0];
  endfunction

  function automatic void push_result(logic [KIND_W-1:0] k, logic [ID_W-1:0] id,
                                      logic [WAIT_W-1:0] w, logic l);
    timer_result_t r;
    r.kind = k; r.result_id = id; r.wait_ms = w; r.last = l;
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void expire_due_timers();
    while (sh_count > 0 && sh_exp[0] <= sh_now) begin
      push_result(KIND_EXPIRED, sh_id[0], '0, 1'b0);
      drop_entry(0);
    end
  endfunction

  // Work out the results of one accepted timer command.
  function automatic void predict_command(logic [MODE_W-1:0] mode, logic [ID_W-1:0] id,
                                          logic [TMO_W-1:0] tmo);
    int s;
    case (mode)
      MODE_SET: begin
        if (sh_valid[id]) begin
          s = sh_slot[id];
          sh_exp[s] = sh_now + TIME_W'(tmo);
          if (!lower_entry(s, sh_count)) raise_entry(s);
          push_result(KIND_DONE, '0, next_wait(), 1'b1);
        end else if (sh_count >= CAPACITY) begin
          push_result(KIND_FULL, '0, '0, 1'b1);
        end else begin
          s = sh_count;
          sh_id[s] = id;
          sh_exp[s] = sh_now + TIME_W'(tmo);
          sh_slot[id] = s;
          sh_valid[id] = 1;
          sh_count = s + 1;
          raise_entry(s);
          push_result(KIND_DONE, '0, next_wait(), 1'b1);
        end
      end
      MODE_FIRE: begin
        if (!sh_valid[id]) begin
          push_result(KIND_NOTFOUND, '0, '0, 1'b1);
        end else begin
          drop_entry(sh_slot[id]);
          push_result(KIND_FIRED, id, '0, 1'b1);
        end
      end
      MODE_TICK: begin
        sh_now = sh_now + TIME_W'(1);
        expire_due_timers();
        push_result(KIND_DONE, '0, next_wait(), 1'b1);
      end
      MODE_QUERY: begin
        expire_due_timers();
        push_result(KIND_DONE, '0, next_wait(), 1'b1);
      end
      MODE_CLEAR: begin
        foreach (sh_valid[i]) sh_valid[i] = 0;
        sh_count = 0;
        push_result(KIND_DONE, '0, next_wait(), 1'b1);
      end
      default: push_result(KIND_DONE, '0, next_wait(), 1'b1);
    endcase
  endfunction

  // Watch both channels at each rising edge.
  always @(posedge clk) begin
    timer_result_t want;
    if (rst) begin
      foreach (sh_valid[i]) sh_valid[i] = 0;
      sh_count = 0;
      sh_now = '0;
      fail_count = 0;
      expected_results.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result item: kind %0d id %0d wait %0d last %0d",
                     out_ch.kind, out_ch.result_id, out_ch.wait_ms, out_ch.last);
        end else begin
          want = expected_results.pop_front();
          if (out_ch.kind !== want.kind || out_ch.result_id !== want.result_id ||
              out_ch.wait_ms !== want.wait_ms || out_ch.last !== want.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected kind %0d id %0d wait %0d last %0d, got %0d %0d %0d %0d",
                       want.kind, want.result_id, want.wait_ms, want.last,
                       out_ch.kind, out_ch.result_id, out_ch.wait_ms, out_ch.last);
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        predict_command(in_ch.mode, in_ch.timer_id, in_ch.timeout_ms);
    end
  end

endmodule

[verif/heap_timer_queue_test.sv]
`timescale 1ns / 1ps
module heap_timer_queue_test;
  import htq_pkg::*;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending_count;
  int   idle_cycles;
  int   burst_left;

  htq_in_if  in_ch();
  htq_out_if out_ch();

  heap_timer_queue i_dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  htq_checker i_checker (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // The receiver stalls on its own pattern: quiet phases and busy phases.
  initial begin
    int phase;
    out_ch.ready = 0;
    phase = 0;
    forever begin
      @(negedge clk);
      phase++;
      if ((phase / 64) % 3 == 0) out_ch.ready <= 1'b1;
      else out_ch.ready <= ($urandom_range(0, 99) < 60);
    end
  end

  // Watchdog on cycles without any accepted item.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("FAIL heap_timer_queue");
      $finish;
    end
  end

  // Hand one command to the block, with bursty gaps before it. Within a
  // burst, valid stays high and only the payload changes.
  task automatic send_command(logic [MODE_W-1:0] mode, logic [ID_W-1:0] id,
                              logic [TMO_W-1:0] tmo);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.timer_id <= id;
    in_ch.timeout_ms <= tmo;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_count != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  initial begin
    int pick;
    logic [ID_W-1:0] id;
    in_ch.valid = 0;
    in_ch.mode = MODE_SET;
    in_ch.timer_id = '0;
    in_ch.timeout_ms = '0;
    burst_left = 0;
    rst = 1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: empty queries, extremes, fire of unknown, re-arm, full heap.
    send_command(MODE_QUERY, 8'd0, '0);
    send_command(MODE_FIRE, 8'd255, '0);
    send_command(MODE_SET, 8'd255, '1);
    send_command(MODE_SET, 8'd0, '0);
    send_command(MODE_SET, 8'd7, 30'd2);
    send_command(MODE_SET, 8'd7, 30'd1);
    send_command(MODE_SET, 8'd255, 30'd3);
    send_command(MODE_TICK, 8'd0, '0);
    send_command(MODE_QUERY, 8'd0, '0);
    send_command(MODE_FIRE, 8'd255, '0);
    send_command(3'd5, 8'd0, '0);
    send_command(3'd7, 8'hff, '1);
    for (int i = 0; i < 33; i++) send_command(MODE_SET, 8'(i + 100), 30'(i % 5 + 1));
    send_command(MODE_TICK, 8'd0, '0);
    send_command(MODE_FIRE, 8'd120, '0);
    send_command(MODE_CLEAR, 8'd0, '0);
    send_command(MODE_QUERY, 8'd0, '0);
    drain_results();

    // Random: mostly sets of few ids with short timeouts, and ticks.
    for (int n = 0; n < 60; n++) begin
      pick = $urandom_range(0, 99);
      id = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 39));
      if (pick < 40)
        send_command(MODE_SET, id, ($urandom_range(0, 9) == 0) ? 30'($urandom)
                                                                : 30'($urandom_range(0, 6)));
      else if (pick < 55) send_command(MODE_FIRE, id, 30'($urandom));
      else if (pick < 80) send_command(MODE_TICK, id, 30'($urandom));
      else if (pick < 90) send_command(MODE_QUERY, id, 30'($urandom));
      else if (pick < 94) send_command(MODE_CLEAR, id, 30'($urandom));
      else send_command(3'($urandom_range(5, 7)), id, 30'($urandom));
      if (n == 30) drain_results();
    end

    drain_results();
    if (fail_count == 0) $display("PASS heap_timer_queue");
    else $display("FAIL heap_timer_queue");
    $finish;
  end

endmodule
